### rtl/core/sks_pkg.sv
// Package for the sorted key set: sizes, command and status codes,
// channel payload structs and the control word shared by the key cells.
// Depends on nothing.
package sks_pkg;

  // Number of key cells in the chain.
  localparam int CAPACITY = 16;
  // Width of a sorted index inside the design.
  localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // Width of the internal key count, which can reach CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Widths of the result fields on the port.
  localparam int OUT_POS_W = 4;
  localparam int OUT_CNT_W = 5;
  localparam int KEY_W = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  // Request payload.
  typedef struct packed {
    cmd_t                     cmd;
    logic signed [KEY_W-1:0]  key;
  } req_t;

  // Response payload.
  typedef struct packed {
    status_t                status;
    logic [OUT_POS_W-1:0]   position;
    logic [OUT_CNT_W-1:0]   count;
  } rsp_t;

  // Control word broadcast to every cell of the chain.
  typedef struct packed {
    logic                     cmp_en;
    cell_op_t                 op;
    logic signed [KEY_W-1:0]  target;
  } cell_ctl_t;

endpackage

### rtl/core/sorted_key_set_unit.sv
// Top level of the sorted key set: request sequencer, key count, response
// register and the chain of key cells.
// Depends on sks_pkg and sks_cell.
//
//   channel | direction | payload | handshake
//   --------+-----------+---------+---------------------------
//   req     | in        | req_t   | req_valid / req_stall
//   rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
// Each request passes through three steps: taking the transfer, all cells
// comparing their keys with the target at once, and decoding the position
// and shifting the chain. Requests are handled one at a time.
// Reset empties the set by clearing the key count; cell contents stay.
// A stalled response holds the sequencer in its last step until taken.
module sorted_key_set_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  sks_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output sks_pkg::rsp_t  rsp
);
  import sks_pkg::*;

  state_t                  state;
  state_t                  state_next;
  req_t                    cur;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  rsp_t                    rsp_next;
  logic                    req_fire;
  logic                    apply_fire;
  cell_ctl_t               ctl;
  cell_op_t                op;

  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [CAPACITY-1:0]     lt_vec;
  logic [CAPACITY-1:0]     eq_vec;
  logic [CAPACITY-1:0]     edge_vec;
  logic [POS_W-1:0]        pos;
  logic                    hit;
  logic                    full;

  assign req_fire   = req_valid && !req_stall;
  assign apply_fire = (state == ST_APPLY) && !(rsp_valid && rsp_stall);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (req_valid) state_next = ST_CMP;
      ST_CMP:   state_next = ST_APPLY;
      ST_APPLY: if (apply_fire) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    req_stall  = (state != ST_IDLE);
    ctl.cmp_en = (state == ST_CMP);
    ctl.op     = apply_fire ? op : CELL_HOLD;
    ctl.target = cur.key;
  end

  // Position of the first entry not below the target. The less-than flags
  // form a run of ones from cell zero, so only one edge bit can be set.
  assign edge_vec = lt_vec & ~(lt_vec >> 1);
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (edge_vec[i]) pos = pos | POS_W'(i + 1);
    end
  end

  assign hit  = |eq_vec;
  assign full = (count == CNT_W'(CAPACITY));

  // Request decode: response, chain operation and new count.
  always_comb begin
    op                = CELL_HOLD;
    count_next        = count;
    rsp_next.status   = STS_OK;
    rsp_next.position = '0;
    unique case (cur.cmd)
      CMD_INSERT: begin
        if (hit) begin
          rsp_next.status   = STS_MISS;
          rsp_next.position = OUT_POS_W'(pos);
        end else if (full) begin
          rsp_next.status = STS_FULL;
        end else begin
          op                = CELL_INSERT;
          count_next        = count + CNT_W'(1);
          rsp_next.position = OUT_POS_W'(pos);
        end
      end
      CMD_REMOVE: begin
        if (!hit) begin
          rsp_next.status = STS_MISS;
        end else begin
          op                = CELL_REMOVE;
          count_next        = count - CNT_W'(1);
          rsp_next.position = OUT_POS_W'(pos);
        end
      end
      CMD_SEARCH: begin
        if (!hit) begin
          rsp_next.status = STS_MISS;
        end else begin
          rsp_next.position = OUT_POS_W'(pos);
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
    rsp_next.count = OUT_CNT_W'(count_next);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_fire) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_fire) cur <= req;
    if (apply_fire) rsp <= rsp_next;
  end

  // Chain of key cells; each sees its neighbors' keys and its left flag.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                    left_lt;
    logic signed [KEY_W-1:0] left_key;
    logic signed [KEY_W-1:0] right_key;

    if (g == 0) begin : g_first
      assign left_lt  = 1'b0;
      assign left_key = cur.key;
    end else begin : g_mid
      assign left_lt  = lt_vec[g-1];
      assign left_key = cell_key[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[g];
    end else begin : g_inner
      assign right_key = cell_key[g+1];
    end

    sks_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .valid     (CNT_W'(g) < count),
      .left_lt   (left_lt),
      .left_key  (left_key),
      .right_key (right_key),
      .key       (cell_key[g]),
      .lt        (lt_vec[g]),
      .eq        (eq_vec[g])
    );
  end

endmodule

### rtl/core/sks_cell.sv
// One cell of the sorted key chain: holds one key, compares it with the
// broadcast target and shifts keys to or from its neighbors.
// Depends on sks_pkg.
module sks_cell (
  input  logic                            clk,
  input  sks_pkg::cell_ctl_t              ctl,
  input  logic                            valid,
  input  logic                            left_lt,
  input  logic signed [sks_pkg::KEY_W-1:0] left_key,
  input  logic signed [sks_pkg::KEY_W-1:0] right_key,
  output logic signed [sks_pkg::KEY_W-1:0] key,
  output logic                            lt,
  output logic                            eq
);
  import sks_pkg::*;

  // Compare flags, taken once per request.
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt <= valid && (key < ctl.target);
      eq <= valid && (key == ctl.target);
    end
  end

  // Key storage. Cells below the handled position hold; the rest shift.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (!lt) begin
          key <= left_lt ? ctl.target : left_key;
        end
      end
      CELL_REMOVE: begin
        if (!lt) begin
          key <= right_key;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
